// ===== hdl/sha1_message_digest_assert.svh =====
// Assertion macros shared by the sha1 digest modules.
// Each macro takes a label, clock, reset and the two sides of an implication.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SMD_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("sha1 digest assertion failed");

// Next-cycle implication.
`define SMD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("sha1 digest assertion failed");

`else

`define SMD_ASSERT_NOW(label, clk, rst, lhs, rhs)
`define SMD_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// ===== hdl/smd_pkg.sv =====
package smd_pkg;

  // SHA-1 initial chaining words
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_LAST   = 7'd79;
  localparam logic [6:0] ROUND_PHASE1 = 7'd20;
  localparam logic [6:0] ROUND_PHASE2 = 7'd40;
  localparam logic [6:0] ROUND_PHASE3 = 7'd60;

  localparam logic [5:0] POS_LAST    = 6'd63;
  localparam logic [5:0] POS_PRE_LEN = 6'd55;  // last slot before the length field
  localparam logic [7:0] PAD_MARK    = 8'h80;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_PAD_MARK = 7'b0000010,
    ST_PAD_ZERO = 7'b0000100,
    ST_PAD_LEN  = 7'b0001000,
    ST_ROUND    = 7'b0010000,
    ST_FOLD     = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR_A,
    FN_MAJ,
    FN_PAR_B
  } round_fn_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic      load_work;
    logic      round_step;
    round_fn_t round_fn;
    logic      fold;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_pre_len;
  } sts_t;

endpackage

// ===== hdl/smd_ctrl.sv =====
`include "sha1_message_digest_assert.svh"

module smd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          byte_valid,
  input  logic          end_of_message,
  output logic          out_valid,
  input  logic          out_stall,
  input  smd_pkg::sts_t sts,
  output smd_pkg::cmd_t cmd
);

  smd_pkg::state_t state, state_next;
  smd_pkg::state_t resume, resume_next;
  logic [6:0]      rnd, rnd_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smd_pkg::ST_IDLE;
      resume    <= smd_pkg::ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      resume    <= resume_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

  // no word is taken while reset is held
  assign in_stall = rst || (state != smd_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    resume_next    = resume;
    rnd_next       = rnd;
    out_valid_next = out_valid & out_stall;

    cmd            = '0;
    cmd.byte_sel   = smd_pkg::SEL_MSG;
    if (rnd < smd_pkg::ROUND_PHASE1)      cmd.round_fn = smd_pkg::FN_CH;
    else if (rnd < smd_pkg::ROUND_PHASE2) cmd.round_fn = smd_pkg::FN_PAR_A;
    else if (rnd < smd_pkg::ROUND_PHASE3) cmd.round_fn = smd_pkg::FN_MAJ;
    else                                  cmd.round_fn = smd_pkg::FN_PAR_B;

    case (state)
      smd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.push = byte_valid;
          if (byte_valid && sts.pos_last) begin
            cmd.load_work = 1'b1;
            state_next    = smd_pkg::ST_ROUND;
            resume_next   = end_of_message ? smd_pkg::ST_PAD_MARK : smd_pkg::ST_IDLE;
          end else if (end_of_message) begin
            state_next = smd_pkg::ST_PAD_MARK;
          end
        end
      end
      smd_pkg::ST_PAD_MARK: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = smd_pkg::SEL_MARK;
        if (sts.pos_last) begin
          cmd.load_work = 1'b1;
          state_next    = smd_pkg::ST_ROUND;
          resume_next   = smd_pkg::ST_PAD_ZERO;
        end else if (sts.pos_pre_len) begin
          state_next = smd_pkg::ST_PAD_LEN;
        end else begin
          state_next = smd_pkg::ST_PAD_ZERO;
        end
      end
      smd_pkg::ST_PAD_ZERO: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = smd_pkg::SEL_ZERO;
        if (sts.pos_last) begin
          cmd.load_work = 1'b1;
          state_next    = smd_pkg::ST_ROUND;
          resume_next   = smd_pkg::ST_PAD_ZERO;
        end else if (sts.pos_pre_len) begin
          state_next = smd_pkg::ST_PAD_LEN;
        end
      end
      smd_pkg::ST_PAD_LEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = smd_pkg::SEL_LEN;
        if (sts.pos_last) begin
          cmd.load_work = 1'b1;
          state_next    = smd_pkg::ST_ROUND;
          resume_next   = smd_pkg::ST_EMIT;
        end
      end
      smd_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (rnd == smd_pkg::ROUND_LAST) begin
          rnd_next   = '0;
          state_next = smd_pkg::ST_FOLD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      smd_pkg::ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = resume;
      end
      smd_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = smd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smd_pkg::ST_IDLE;
      end
    endcase
  end

  `SMD_ASSERT_NEXT(a_round_to_fold, clk, rst,
                   state == smd_pkg::ST_ROUND && rnd == smd_pkg::ROUND_LAST,
                   state == smd_pkg::ST_FOLD)
  `SMD_ASSERT_NEXT(a_len_full_emits, clk, rst,
                   state == smd_pkg::ST_PAD_LEN && sts.pos_last,
                   state == smd_pkg::ST_ROUND && resume == smd_pkg::ST_EMIT)
  `SMD_ASSERT_NEXT(a_emit_waits, clk, rst,
                   state == smd_pkg::ST_EMIT && out_valid && out_stall,
                   state == smd_pkg::ST_EMIT && out_valid)

endmodule

// ===== hdl/smd_datapath.sv =====
`include "sha1_message_digest_assert.svh"

module smd_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    message_byte,
  input  smd_pkg::cmd_t cmd,
  output smd_pkg::sts_t sts,
  output logic [31:0]   digest_word0,
  output logic [31:0]   digest_word1,
  output logic [31:0]   digest_word2,
  output logic [31:0]   digest_word3,
  output logic [31:0]   digest_word4
);

  // 16-word window: bytes shift in during fill, schedule words during rounds
  logic [511:0] window;
  logic [31:0]  wa, wb, wc, wd, we;
  logic [31:0]  chain [5];
  logic [63:0]  bit_total;
  logic [5:0]   pos;

  logic [7:0]   push_byte;
  logic [7:0]   len_byte;
  logic [31:0]  w_cur, w_mix, w_new;
  logic [31:0]  f_val, k_val, t_val;

  assign sts.pos_last    = (pos == smd_pkg::POS_LAST);
  assign sts.pos_pre_len = (pos == smd_pkg::POS_PRE_LEN);

  // length field, most significant byte at slot 56
  assign len_byte = 8'(bit_total >> {~pos[2:0], 3'b000});

  always_comb begin
    case (cmd.byte_sel)
      smd_pkg::SEL_MSG:  push_byte = message_byte;
      smd_pkg::SEL_MARK: push_byte = smd_pkg::PAD_MARK;
      smd_pkg::SEL_ZERO: push_byte = 8'h00;
      smd_pkg::SEL_LEN:  push_byte = len_byte;
      default:           push_byte = 8'h00;
    endcase
  end

  // window slot 0 holds w[t]; next word from slots 13, 8, 2, 0
  assign w_cur = window[511:480];
  assign w_mix = window[95:64] ^ window[255:224] ^ window[447:416] ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.round_fn)
      smd_pkg::FN_CH: begin
        f_val = (wb & wc) | (~wb & wd);
        k_val = smd_pkg::K0;
      end
      smd_pkg::FN_PAR_A: begin
        f_val = wb ^ wc ^ wd;
        k_val = smd_pkg::K1;
      end
      smd_pkg::FN_MAJ: begin
        f_val = (wb & wc) | (wb & wd) | (wc & wd);
        k_val = smd_pkg::K2;
      end
      smd_pkg::FN_PAR_B: begin
        f_val = wb ^ wc ^ wd;
        k_val = smd_pkg::K3;
      end
      default: begin
        f_val = '0;
        k_val = '0;
      end
    endcase
  end

  assign t_val = {wa[26:0], wa[31:27]} + f_val + we + k_val + w_cur;

  // control-side counters and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bit_total <= '0;
      chain[0]  <= smd_pkg::IV0;
      chain[1]  <= smd_pkg::IV1;
      chain[2]  <= smd_pkg::IV2;
      chain[3]  <= smd_pkg::IV3;
      chain[4]  <= smd_pkg::IV4;
    end else begin
      if (cmd.push) begin
        pos <= pos + 6'd1;
        if (cmd.byte_sel == smd_pkg::SEL_MSG) begin
          bit_total <= bit_total + 64'd8;
        end
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
      if (cmd.emit) begin
        bit_total <= '0;
        chain[0]  <= smd_pkg::IV0;
        chain[1]  <= smd_pkg::IV1;
        chain[2]  <= smd_pkg::IV2;
        chain[3]  <= smd_pkg::IV3;
        chain[4]  <= smd_pkg::IV4;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      window <= {window[503:0], push_byte};
    end else if (cmd.round_step) begin
      window <= {window[479:0], w_new};
    end
    if (cmd.load_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round_step) begin
      wa <= t_val;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
    if (cmd.emit) begin
      digest_word0 <= chain[0];
      digest_word1 <= chain[1];
      digest_word2 <= chain[2];
      digest_word3 <= chain[3];
      digest_word4 <= chain[4];
    end
  end

  `SMD_ASSERT_NOW(a_push_not_round, clk, rst, cmd.push, !cmd.round_step && !cmd.fold)
  `SMD_ASSERT_NEXT(a_emit_reinit, clk, rst, cmd.emit,
                   bit_total == 64'd0 && pos == 6'd0 && chain[0] == smd_pkg::IV0)

endmodule

// ===== hdl/sha1_message_digest.sv =====
// Channel  Direction  Handshake             Word
// -------  ---------  --------------------  -----------------------------------------
// in       to block   in_valid / in_stall   byte_valid, message_byte, end_of_message
// out      from block out_valid / out_stall digest_word0 .. digest_word4
//
// Intake: message bytes are taken while idle; each full 64-byte block then holds the
//   input stalled while its 80 rounds run on one shared round unit and one fold
//   adds the result into the chaining words.
// End of message: the padding bytes are pushed one after another (up to 64, 72 when
//   the padding crosses a block boundary), then one or two extra compressions run
//   and the digest is loaded.
// Reset: synchronous, active high; chaining words return to the SHA-1 start values.
// Stalls: the digest waits in its output register; input resumes while it waits,
//   and only a second digest blocks until the first is taken.

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        byte_valid,
  input  logic [7:0]  message_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  // command and status between sequencer and datapath
  smd_pkg::cmd_t cmd;
  smd_pkg::sts_t sts;

  // sequencer: byte intake, padding, round counting, digest handoff
  smd_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  // datapath: block window, round unit, chaining words, length, digest words
  smd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .message_byte (message_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

endmodule
